// ===== rtl/core/tls_client_hello_sni_extractor_macros.svh =====
// Assertion macros shared by the checker of the SNI extractor.
// Expects signals clk and rst_n in the scope of each use.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLSSNI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Value holds into the next cycle when the antecedent is true.
`define TLSSNI_ASSERT_HOLD(lbl, ante, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/core/tlssni_pkg.sv =====
// Types and constants of the TLS ClientHello SNI extractor.
// No dependencies; used by every module of the block.
package tlssni_pkg;

  localparam logic [7:0]  REC_HANDSHAKE    = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO  = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;
  localparam logic [7:0]  NAME_TYPE_HOST   = 8'h00;
  localparam int          HDR_LEN          = 9;
  localparam int          HELLO_FIXED_LEN  = 34;
  localparam int          MIN_RECORD_LEN   = 6;
  localparam int          HS_TYPE_POS      = 5;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_HELLO = 2'd1,
    ST_TRUNC     = 2'd2,
    ST_NO_NAME   = 2'd3
  } status_t;

  typedef enum logic [15:0] {
    PH_IDLE      = 16'h0001,
    PH_HS_TYPE   = 16'h0002,
    PH_SID_LEN   = 16'h0004,
    PH_CS_HI     = 16'h0008,
    PH_CS_LO     = 16'h0010,
    PH_CM_LEN    = 16'h0020,
    PH_EXTS_HI   = 16'h0040,
    PH_EXTS_LO   = 16'h0080,
    PH_EXT_T0    = 16'h0100,
    PH_EXT_T1    = 16'h0200,
    PH_EXT_L0    = 16'h0400,
    PH_EXT_L1    = 16'h0800,
    PH_NAME_TYPE = 16'h1000,
    PH_NAME_HI   = 16'h2000,
    PH_NAME_LO   = 16'h4000,
    PH_NAME      = 16'h8000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] payload_length;
  } item_t;

  typedef struct packed {
    logic       name_valid;
    logic [7:0] name_byte;
    logic       verdict_valid;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/core/tls_client_hello_sni_extractor.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | data_byte, first_byte, payload_length
// out_    | output    | out_valid/out_stall| name_valid, name_byte, verdict_valid, status
//
// One byte per cycle while in_stall is low; the result of a byte passes the input
// register, the parser and a result buffer write before it reaches the out_ port.
// Each byte is parsed by the phase machine in tlssni_parser.
// rst_n is synchronous; in_stall is low from the first reset edge on, so a
// transfer can be taken at the first edge with rst_n high.
// in_stall rises only when the input register is full and the two-entry
// result buffer is full; out_stall backs up through that buffer.
// Top level of the TLS ClientHello SNI extractor; uses tlssni_pkg,
// tlssni_in_reg, tlssni_parser and tlssni_out_fifo.
module tls_client_hello_sni_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_payload_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_name_valid,
  output logic [7:0]  out_name_byte,
  output logic        out_verdict_valid,
  output logic [1:0]  out_status
);

  logic                fifo_full;
  logic                fire;
  tlssni_pkg::item_t   item;
  logic                push;
  tlssni_pkg::result_t res;
  tlssni_pkg::result_t res_out;

  tlssni_in_reg u_in_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_payload_length (in_payload_length),
    .out_full_i        (fifo_full),
    .fire_o            (fire),
    .item_o            (item)
  );

  tlssni_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .item_i (item),
    .push_o (push),
    .res_o  (res)
  );

  tlssni_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .res_i     (res),
    .full_o    (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (res_out)
  );

  assign out_name_valid    = res_out.name_valid;
  assign out_name_byte     = res_out.name_byte;
  assign out_verdict_valid = res_out.verdict_valid;
  assign out_status        = res_out.status;

endmodule

// ===== rtl/core/tlssni_in_reg.sv =====
// Input register of the SNI extractor: holds one byte transfer until the
// parser takes it. Depends on tlssni_pkg.
module tlssni_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic [15:0]          in_payload_length,
  input  logic                 out_full_i,
  output logic                 fire_o,
  output tlssni_pkg::item_t    item_o
);

  logic              vld_r, vld_nxt;
  tlssni_pkg::item_t item_r;
  logic              accept;

  assign in_stall = vld_r & out_full_i;
  assign fire_o   = vld_r & ~out_full_i;
  assign accept   = in_valid & ~in_stall;
  assign vld_nxt  = accept | (vld_r & ~fire_o);
  assign item_o   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte      <= in_data_byte;
      item_r.first_byte     <= in_first_byte;
      item_r.payload_length <= in_payload_length;
    end
  end

endmodule

// ===== rtl/core/tlssni_parser.sv =====
// Byte-wise ClientHello parser: phase machine, position and skip counters,
// length checks and result generation. Depends on tlssni_pkg.
module tlssni_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire_i,
  input  tlssni_pkg::item_t     item_i,
  output logic                  push_o,
  output tlssni_pkg::result_t   res_o
);

  tlssni_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [16:0] exts_end_r, exts_end_nxt;
  logic [16:0] ext_end_r, ext_end_nxt;

  logic [15:0] pos;
  logic [7:0]  b;
  logic [17:0] p18, b18, n18, plen18;
  logic [17:0] sum_pb;
  logic [17:0] sum_pn;
  logic [17:0] ext_tmp;
  logic [15:0] acc_dec;
  logic        do_walk;
  logic [17:0] walk_next;
  logic        do_goto;
  tlssni_pkg::phase_t goto_phase;
  logic [17:0] goto_next;
  logic        vrd;
  tlssni_pkg::status_t vrd_code;

  assign pos     = pos_r + 16'd1;
  assign b       = item_i.data_byte;
  assign p18     = {2'b00, pos};
  assign b18     = {10'd0, b};
  assign n18     = {2'b00, acc_r | {8'd0, b}};
  assign plen18  = {2'b00, plen_r};
  assign sum_pb  = p18 + 18'd1 + b18;
  assign sum_pn  = p18 + 18'd1 + n18;
  assign acc_dec = acc_r - 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    plen_nxt     = plen_r;
    skip_nxt     = skip_r;
    acc_nxt      = acc_r;
    exts_end_nxt = exts_end_r;
    ext_end_nxt  = ext_end_r;
    push_o       = 1'b0;
    res_o        = '0;
    do_walk      = 1'b0;
    walk_next    = '0;
    do_goto      = 1'b0;
    goto_phase   = phase_r;
    goto_next    = '0;
    vrd          = 1'b0;
    vrd_code     = tlssni_pkg::ST_FOUND;
    ext_tmp      = '0;

    if (fire_i) begin
      if (item_i.first_byte) begin
        pos_nxt      = '0;
        plen_nxt     = item_i.payload_length;
        skip_nxt     = '0;
        acc_nxt      = '0;
        exts_end_nxt = '0;
        ext_end_nxt  = '0;
        if (item_i.payload_length < 16'(tlssni_pkg::MIN_RECORD_LEN) ||
            b != tlssni_pkg::REC_HANDSHAKE) begin
          vrd      = 1'b1;
          vrd_code = tlssni_pkg::ST_NOT_HELLO;
        end else begin
          phase_nxt = tlssni_pkg::PH_HS_TYPE;
          skip_nxt  = 16'(tlssni_pkg::HS_TYPE_POS - 1);
        end
      end else if (phase_r != tlssni_pkg::PH_IDLE) begin
        pos_nxt = pos;
        if (skip_r != 16'd0) begin
          skip_nxt = skip_r - 16'd1;
        end else begin
          unique case (phase_r)
            tlssni_pkg::PH_HS_TYPE: begin
              if (b != tlssni_pkg::HS_CLIENT_HELLO) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_NOT_HELLO;
              end else if (plen18 <
                  18'(tlssni_pkg::HDR_LEN + tlssni_pkg::HELLO_FIXED_LEN + 1)) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_TRUNC;
              end else begin
                do_goto    = 1'b1;
                goto_phase = tlssni_pkg::PH_SID_LEN;
                goto_next  = 18'(tlssni_pkg::HDR_LEN + tlssni_pkg::HELLO_FIXED_LEN);
              end
            end
            tlssni_pkg::PH_SID_LEN, tlssni_pkg::PH_CM_LEN: begin
              if (sum_pb + 18'd2 > plen18) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_TRUNC;
              end else begin
                do_goto    = 1'b1;
                goto_phase = (phase_r == tlssni_pkg::PH_SID_LEN) ?
                             tlssni_pkg::PH_CS_HI : tlssni_pkg::PH_EXTS_HI;
                goto_next  = sum_pb;
              end
            end
            tlssni_pkg::PH_CS_HI: begin
              acc_nxt   = {b, 8'd0};
              phase_nxt = tlssni_pkg::PH_CS_LO;
            end
            tlssni_pkg::PH_EXTS_HI: begin
              acc_nxt   = {b, 8'd0};
              phase_nxt = tlssni_pkg::PH_EXTS_LO;
            end
            tlssni_pkg::PH_NAME_HI: begin
              acc_nxt   = {b, 8'd0};
              phase_nxt = tlssni_pkg::PH_NAME_LO;
            end
            tlssni_pkg::PH_CS_LO: begin
              if (sum_pn + 18'd1 > plen18) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_TRUNC;
              end else begin
                do_goto    = 1'b1;
                goto_phase = tlssni_pkg::PH_CM_LEN;
                goto_next  = sum_pn;
              end
            end
            tlssni_pkg::PH_EXTS_LO: begin
              exts_end_nxt = sum_pn[16:0];
              do_walk      = 1'b1;
              walk_next    = p18 + 18'd1;
            end
            tlssni_pkg::PH_EXT_T0: begin
              acc_nxt   = {b, 8'd0};
              phase_nxt = tlssni_pkg::PH_EXT_T1;
            end
            tlssni_pkg::PH_EXT_T1: begin
              acc_nxt   = acc_r | {8'd0, b};
              phase_nxt = tlssni_pkg::PH_EXT_L0;
            end
            tlssni_pkg::PH_EXT_L0: begin
              ext_tmp     = p18 + 18'd2 + {2'b00, b, 8'd0};
              ext_end_nxt = ext_tmp[16:0];
              phase_nxt   = tlssni_pkg::PH_EXT_L1;
            end
            tlssni_pkg::PH_EXT_L1: begin
              ext_end_nxt = ext_end_r + {9'd0, b};
              if (acc_r == tlssni_pkg::EXT_SERVER_NAME) begin
                // list length is skipped, name type follows it
                if (p18 + 18'd6 > plen18) begin
                  vrd      = 1'b1;
                  vrd_code = tlssni_pkg::ST_TRUNC;
                end else begin
                  do_goto    = 1'b1;
                  goto_phase = tlssni_pkg::PH_NAME_TYPE;
                  goto_next  = p18 + 18'd3;
                end
              end else begin
                do_walk   = 1'b1;
                walk_next = {1'b0, ext_end_nxt};
              end
            end
            tlssni_pkg::PH_NAME_TYPE: begin
              if (b != tlssni_pkg::NAME_TYPE_HOST) begin
                do_walk   = 1'b1;
                walk_next = ({1'b0, ext_end_r} > p18) ? {1'b0, ext_end_r} : p18 + 18'd1;
              end else begin
                phase_nxt = tlssni_pkg::PH_NAME_HI;
              end
            end
            tlssni_pkg::PH_NAME_LO: begin
              if (sum_pn > plen18) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_TRUNC;
              end else if (n18 == 18'd0) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_NO_NAME;
              end else begin
                acc_nxt   = n18[15:0];
                phase_nxt = tlssni_pkg::PH_NAME;
              end
            end
            tlssni_pkg::PH_NAME: begin
              acc_nxt          = acc_dec;
              push_o           = 1'b1;
              res_o.name_valid = 1'b1;
              res_o.name_byte  = b;
              if (acc_dec == 16'd0) begin
                vrd      = 1'b1;
                vrd_code = tlssni_pkg::ST_FOUND;
              end
            end
            default: begin
              phase_nxt = tlssni_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end

    // next extension header: end of block first, then payload length
    if (do_walk) begin
      if (walk_next + 18'd4 > {1'b0, exts_end_nxt}) begin
        vrd      = 1'b1;
        vrd_code = tlssni_pkg::ST_NO_NAME;
      end else if (walk_next + 18'd4 > plen18) begin
        vrd      = 1'b1;
        vrd_code = tlssni_pkg::ST_TRUNC;
      end else begin
        do_goto    = 1'b1;
        goto_phase = tlssni_pkg::PH_EXT_T0;
        goto_next  = walk_next;
      end
    end

    if (do_goto) begin
      phase_nxt = goto_phase;
      skip_nxt  = goto_next[15:0] - pos - 16'd1;
    end

    if (vrd) begin
      phase_nxt           = tlssni_pkg::PH_IDLE;
      skip_nxt            = '0;
      push_o              = 1'b1;
      res_o.verdict_valid = 1'b1;
      res_o.status        = vrd_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= tlssni_pkg::PH_IDLE;
      pos_r      <= '0;
      plen_r     <= '0;
      skip_r     <= '0;
      acc_r      <= '0;
      exts_end_r <= '0;
      ext_end_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      plen_r     <= plen_nxt;
      skip_r     <= skip_nxt;
      acc_r      <= acc_nxt;
      exts_end_r <= exts_end_nxt;
      ext_end_r  <= ext_end_nxt;
    end
  end

endmodule

// ===== rtl/core/tlssni_out_fifo.sv =====
// Two-entry result buffer; lets the parser run while a result waits for the
// sink. Depends on tlssni_pkg.
module tlssni_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  tlssni_pkg::result_t  res_i,
  output logic                 full_o,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlssni_pkg::result_t  res_o
);

  tlssni_pkg::result_t mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       pop;

  assign out_valid  = (count_r != 2'd0);
  assign full_o     = (count_r == 2'd2);
  assign pop        = out_valid & ~out_stall;
  assign res_o      = mem_r[rd_ptr_r];
  assign wr_ptr_nxt = wr_ptr_r ^ push_i;
  assign rd_ptr_nxt = rd_ptr_r ^ pop;

  always_comb begin
    unique case ({push_i, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= res_i;
    end
  end

endmodule

// ===== rtl/core/tlssni_checker.sv =====
// Port-level checks for the SNI extractor, bound to its top level.
// Depends on tlssni_pkg and the shared assertion macros header.
`include "tls_client_hello_sni_extractor_macros.svh"

module tlssni_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_first_byte,
  input logic [15:0] in_payload_length,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_name_valid,
  input logic [7:0]  out_name_byte,
  input logic        out_verdict_valid,
  input logic [1:0]  out_status
);

  // a stalled input transfer keeps its payload
  `TLSSNI_ASSERT_HOLD(a_in_hold, in_valid && in_stall,
    ({in_valid, in_data_byte, in_first_byte, in_payload_length}),
    "input changed while stalled")

  // a stalled result transfer keeps its payload
  `TLSSNI_ASSERT_HOLD(a_out_hold, out_valid && out_stall,
    ({out_valid, out_name_valid, out_name_byte, out_verdict_valid, out_status}),
    "result changed while stalled")

  // every result carries a name byte or a verdict
  `TLSSNI_ASSERT_IMP(a_out_nonempty, out_valid, out_name_valid || out_verdict_valid,
    "empty result")

  // a found verdict always rides on the last host-name byte
  `TLSSNI_ASSERT_IMP(a_found_has_byte,
    out_valid && out_verdict_valid && out_status == tlssni_pkg::ST_FOUND,
    out_name_valid, "found verdict without name byte")

  // fields that are not flagged read as zero
  `TLSSNI_ASSERT_IMP(a_unflagged_zero, out_valid,
    (out_name_valid || out_name_byte == 8'd0) &&
    (out_verdict_valid || out_status == 2'd0), "unflagged field not zero")

endmodule

bind tls_client_hello_sni_extractor tlssni_checker u_tlssni_checker (.*);

// ===== dv/sni_stream_checker.sv =====
// Checker for the TLS ClientHello SNI extractor: predicts the name bytes and verdicts
// from the input transfers and compares them with the result transfers.
// Depends on tlssni_pkg for the status enum, the phase enum and the protocol constants.
module sni_stream_checker
  import tlssni_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [15:0] in_payload_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_name_valid,
  input  logic [7:0]  out_name_byte,
  input  logic        out_verdict_valid,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          results_pending
);

  phase_t      hello_phase;
  logic [15:0] byte_pos;
  logic [15:0] rec_len;
  logic [15:0] skip_left;
  logic [15:0] field_acc;
  logic [16:0] ext_block_end;
  logic [16:0] cur_ext_end;
  result_t     sni_expected_q[$];
  int          mismatches;

  // Next field starts at position nxt; bytes in between are skipped.
  task automatic jump(input phase_t ph, input int unsigned nxt);
    hello_phase = ph;
    skip_left   = 16'(nxt - byte_pos - 1);
  endtask

  task automatic conclude(input status_t st, output bit made, output result_t res);
    made              = 1'b1;
    res               = '0;
    res.verdict_valid = 1'b1;
    res.status        = st;
    hello_phase       = PH_IDLE;
    skip_left         = '0;
  endtask

  // Another extension header may start at nxt.
  task automatic walk_to(input int unsigned nxt, output bit made, output result_t res);
    if (nxt + 4 > ext_block_end) begin
      conclude(ST_NO_NAME, made, res);
    end else if (nxt + 4 > rec_len) begin
      conclude(ST_TRUNC, made, res);
    end else begin
      jump(PH_EXT_T0, nxt);
    end
  endtask

  task automatic predict_sni_byte(input logic [7:0] b, input logic first,
                                  input logic [15:0] len, output bit made,
                                  output result_t res);
    int unsigned p;
    int unsigned n;
    int unsigned nxt;
    made = 1'b0;
    res  = '0;
    if (first) begin
      byte_pos      = '0;
      rec_len       = len;
      skip_left     = '0;
      field_acc     = '0;
      ext_block_end = '0;
      cur_ext_end   = '0;
      if (len < MIN_RECORD_LEN || b != REC_HANDSHAKE) begin
        conclude(ST_NOT_HELLO, made, res);
      end else begin
        jump(PH_HS_TYPE, HS_TYPE_POS);
      end
      return;
    end
    if (hello_phase == PH_IDLE) return;
    byte_pos = byte_pos + 16'd1;
    if (skip_left != 0) begin
      skip_left = skip_left - 16'd1;
      return;
    end
    p = byte_pos;
    case (hello_phase)
      PH_HS_TYPE: begin
        if (b != HS_CLIENT_HELLO) begin
          conclude(ST_NOT_HELLO, made, res);
        end else if (rec_len < HDR_LEN + HELLO_FIXED_LEN + 1) begin
          conclude(ST_TRUNC, made, res);
        end else begin
          jump(PH_SID_LEN, HDR_LEN + HELLO_FIXED_LEN);
        end
      end
      PH_SID_LEN: begin
        nxt = p + 1 + b;
        if (nxt + 2 > rec_len) conclude(ST_TRUNC, made, res);
        else jump(PH_CS_HI, nxt);
      end
      PH_CS_HI: begin
        field_acc   = {b, 8'h00};
        hello_phase = PH_CS_LO;
      end
      PH_EXTS_HI: begin
        field_acc   = {b, 8'h00};
        hello_phase = PH_EXTS_LO;
      end
      PH_NAME_HI: begin
        field_acc   = {b, 8'h00};
        hello_phase = PH_NAME_LO;
      end
      PH_CS_LO: begin
        n   = field_acc | b;
        nxt = p + 1 + n;
        if (nxt + 1 > rec_len) conclude(ST_TRUNC, made, res);
        else jump(PH_CM_LEN, nxt);
      end
      PH_CM_LEN: begin
        nxt = p + 1 + b;
        if (nxt + 2 > rec_len) conclude(ST_TRUNC, made, res);
        else jump(PH_EXTS_HI, nxt);
      end
      PH_EXTS_LO: begin
        n             = field_acc | b;
        ext_block_end = 17'(p + 1 + n);
        walk_to(p + 1, made, res);
      end
      PH_EXT_T0: begin
        field_acc   = {b, 8'h00};
        hello_phase = PH_EXT_T1;
      end
      PH_EXT_T1: begin
        field_acc   = field_acc | b;
        hello_phase = PH_EXT_L0;
      end
      PH_EXT_L0: begin
        cur_ext_end = 17'(p + 2 + {b, 8'h00});
        hello_phase = PH_EXT_L1;
      end
      PH_EXT_L1: begin
        cur_ext_end = cur_ext_end + b;
        if (field_acc == EXT_SERVER_NAME) begin
          // list length is skipped, then name type and name length
          if (p + 6 > rec_len) conclude(ST_TRUNC, made, res);
          else jump(PH_NAME_TYPE, p + 3);
        end else begin
          walk_to(cur_ext_end, made, res);
        end
      end
      PH_NAME_TYPE: begin
        if (b != NAME_TYPE_HOST) begin
          // an extension too short to hold its header resumes at the next byte
          nxt = (cur_ext_end > p) ? cur_ext_end : p + 1;
          walk_to(nxt, made, res);
        end else begin
          hello_phase = PH_NAME_HI;
        end
      end
      PH_NAME_LO: begin
        n = field_acc | b;
        if (p + 1 + n > rec_len) begin
          conclude(ST_TRUNC, made, res);
        end else if (n == 0) begin
          conclude(ST_NO_NAME, made, res);
        end else begin
          field_acc   = 16'(n);
          hello_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        field_acc      = field_acc - 16'd1;
        made           = 1'b1;
        res.name_valid = 1'b1;
        res.name_byte  = b;
        if (field_acc == 0) begin
          res.verdict_valid = 1'b1;
          res.status        = ST_FOUND;
          hello_phase       = PH_IDLE;
          skip_left         = '0;
        end
      end
      default: hello_phase = PH_IDLE;
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t fresh;
    bit      made;
    if (!rst_n) begin
      hello_phase   = PH_IDLE;
      byte_pos      = '0;
      rec_len       = '0;
      skip_left     = '0;
      field_acc     = '0;
      ext_block_end = '0;
      cur_ext_end   = '0;
      sni_expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.name_valid    = out_name_valid;
        got.name_byte     = out_name_byte;
        got.verdict_valid = out_verdict_valid;
        got.status        = status_t'(out_status);
        if (sni_expected_q.size() == 0) begin
          $error("result transfer with nothing expected: name_valid %0b name_byte %0h %s",
                 got.name_valid, got.name_byte, "verdict");
          mismatches++;
        end else begin
          want = sni_expected_q.pop_front();
          check_field("name_valid", want.name_valid, got.name_valid);
          check_field("name_byte", want.name_byte, got.name_byte);
          check_field("verdict_valid", want.verdict_valid, got.verdict_valid);
          check_field("status", want.status, got.status);
        end
      end
      if (in_valid && !in_stall) begin
        predict_sni_byte(in_data_byte, in_first_byte, in_payload_length, made, fresh);
        if (made) sni_expected_q = {sni_expected_q, fresh};
      end
    end
    results_pending <= sni_expected_q.size();
    fail_count      <= mismatches;
  end

  initial mismatches = 0;

endmodule

// ===== dv/tls_client_hello_sni_extractor_tb.sv =====
// Testbench top for the TLS ClientHello SNI extractor: drives byte streams of
// well-formed, cut, abandoned and corrupted ClientHello records with random stalls.
// Depends on tlssni_pkg, the extractor RTL and sni_stream_checker.
module tls_client_hello_sni_extractor_tb;
  import tlssni_pkg::*;

  localparam int RANDOM_ITEMS   = 900;
  localparam int QUIET_TAIL     = 90;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    SNI_HOST,
    SNI_OTHER_TYPE,
    SNI_SHORT_EXT,
    SNI_EMPTY,
    SNI_ABSENT
  } sni_shape_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic [15:0] in_payload_length = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_name_valid;
  logic [7:0]  out_name_byte;
  logic        out_verdict_valid;
  logic [1:0]  out_status;
  int          fail_count;
  int          results_pending;

  int          items_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          quiet = 1'b0;
  logic [7:0]  record_q[$];

  tls_client_hello_sni_extractor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_payload_length (in_payload_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_name_valid    (out_name_valid),
    .out_name_byte     (out_name_byte),
    .out_verdict_valid (out_verdict_valid),
    .out_status        (out_status)
  );

  sni_stream_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_payload_length (in_payload_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_name_valid    (out_name_valid),
    .out_name_byte     (out_name_byte),
    .out_verdict_valid (out_verdict_valid),
    .out_status        (out_status),
    .fail_count        (fail_count),
    .results_pending   (results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
    if (!tx_calm && !quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_first_byte     <= first;
    in_payload_length <= len;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // First count bytes of the built record; len goes with the first one.
  task automatic send_record(input int count, input logic [15:0] len);
    for (int i = 0; i < count; i++) begin
      send_byte(record_q[i], i == 0, (i == 0) ? len : 16'($urandom));
    end
  endtask

  task automatic add_byte(input logic [7:0] v);
    record_q = {record_q, v};
  endtask

  task automatic push_u16(input logic [15:0] v);
    add_byte(v[15:8]);
    add_byte(v[7:0]);
  endtask

  task automatic push_noise(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic add_plain_ext();
    int len;
    len = $urandom_range(0, 4);
    push_u16(16'($urandom_range(1, 65535)));
    push_u16(16'(len));
    push_noise(len);
  endtask

  // squeeze: declared length too short to cover the name type byte
  task automatic add_sni_ext(input logic [7:0] ntype, input int name_len, input bit squeeze);
    int body;
    body = 5 + name_len;
    push_u16(EXT_SERVER_NAME);
    if (squeeze) begin
      push_u16(16'($urandom_range(0, 2)));
      push_noise(2);
      add_byte(ntype);
    end else begin
      push_u16(16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, body) : body));
      push_u16(16'(body - 2));
      add_byte(ntype);
      push_u16(16'(name_len));
      push_noise(name_len);
    end
  endtask

  task automatic build_hello();
    sni_shape_t shape;
    int         sid;
    int         cs;
    int         cm;
    int         exts_at;
    int         exts_len;
    int         roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) shape = SNI_HOST;
    else if (roll == 5) shape = SNI_OTHER_TYPE;
    else if (roll == 6) shape = SNI_SHORT_EXT;
    else if (roll == 7) shape = SNI_EMPTY;
    else shape = SNI_ABSENT;
    roll = $urandom_range(0, 15);
    if (roll == 0) sid = $urandom_range(33, 255);
    else if (roll < 3) sid = 32;
    else sid = $urandom_range(0, 3);
    cs = 2 * $urandom_range(1, 3);
    cm = $urandom_range(1, 2);
    record_q.delete();
    add_byte(REC_HANDSHAKE);
    push_noise(HS_TYPE_POS - 1);
    add_byte(HS_CLIENT_HELLO);
    push_noise(HDR_LEN - HS_TYPE_POS - 1 + HELLO_FIXED_LEN);
    add_byte(8'(sid));
    push_noise(sid);
    push_u16(16'(cs));
    push_noise(cs);
    add_byte(8'(cm));
    push_noise(cm);
    exts_at = record_q.size();
    push_u16(16'h0000);
    repeat ($urandom_range(0, 1)) add_plain_ext();
    case (shape)
      SNI_HOST: add_sni_ext(NAME_TYPE_HOST, $urandom_range(1, 20), 1'b0);
      SNI_OTHER_TYPE: begin
        add_sni_ext(8'($urandom_range(1, 255)), $urandom_range(0, 6), 1'b0);
        if ($urandom_range(0, 1)) add_sni_ext(NAME_TYPE_HOST, $urandom_range(1, 20), 1'b0);
      end
      SNI_SHORT_EXT: begin
        add_sni_ext(8'($urandom_range(1, 255)), 0, 1'b1);
        add_sni_ext(NAME_TYPE_HOST, $urandom_range(1, 20), 1'b0);
      end
      SNI_EMPTY: add_sni_ext(NAME_TYPE_HOST, 0, 1'b0);
      default: ;
    endcase
    repeat ($urandom_range(0, 1)) add_plain_ext();
    exts_len = record_q.size() - exts_at - 2;
    if ($urandom_range(0, 9) == 0) exts_len = $urandom_range(0, exts_len);
    record_q[exts_at]     = exts_len[15:8];
    record_q[exts_at + 1] = exts_len[7:0];
  endtask

  // Receiver stalls in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int  random_start;
    int  roll;
    int  len;
    int  count;
    bit  paused;
    logic [7:0] b;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle stray byte, short records, header boundaries, restart
    send_byte(8'hFF, 1'b0, 16'hFFFF);
    send_byte(REC_HANDSHAKE, 1'b1, 16'd0);
    send_byte(REC_HANDSHAKE, 1'b1, 16'(MIN_RECORD_LEN - 1));
    send_byte(8'h00, 1'b1, 16'hFFFF);
    record_q = '{REC_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'hFF, HS_CLIENT_HELLO};
    send_record(6, 16'(HDR_LEN + HELLO_FIXED_LEN));
    record_q[5] = 8'hFF;
    send_record(6, 16'(HDR_LEN + HELLO_FIXED_LEN + 1));
    send_byte(8'h00, 1'b0, 16'h0000);
    send_record(2, 16'd300);
    send_byte(8'h17, 1'b1, 16'(MIN_RECORD_LEN));

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (!paused && items_sent - random_start >= RANDOM_ITEMS / 2) begin
        // hold the sender until every outstanding result has drained
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
      end
      roll = $urandom_range(0, 19);
      if (roll < 11) begin
        build_hello();
        len = ($urandom_range(0, 15) == 0) ? 16'hFFFF : record_q.size();
        send_record(record_q.size(), 16'(len));
      end else if (roll < 14) begin
        build_hello();
        len   = $urandom_range(MIN_RECORD_LEN, record_q.size() - 1);
        count = len + $urandom_range(0, 3);
        if (count > record_q.size()) count = record_q.size();
        send_record(count, 16'(len));
      end else if (roll < 16) begin
        // abandoned mid-record; the next first byte restarts the parse
        build_hello();
        send_record($urandom_range(1, record_q.size() - 1), 16'(record_q.size()));
      end else if (roll == 16) begin
        build_hello();
        do b = 8'($urandom); while (b == HS_CLIENT_HELLO);
        record_q[HS_TYPE_POS] = b;
        send_record($urandom_range(HS_TYPE_POS + 1, HS_TYPE_POS + 3), 16'(record_q.size()));
      end else if (roll < 19) begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 2 * MIN_RECORD_LEN) : $urandom;
        b   = $urandom_range(0, 1) ? REC_HANDSHAKE : 8'($urandom);
        send_byte(b, 1'b1, 16'(len));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 16'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 16'($urandom));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== tls_client_hello_sni_extractor.f =====
+incdir+rtl/core
rtl/core/tlssni_pkg.sv
rtl/core/tlssni_in_reg.sv
rtl/core/tlssni_parser.sv
rtl/core/tlssni_out_fifo.sv
rtl/core/tls_client_hello_sni_extractor.sv
rtl/core/tlssni_checker.sv
dv/sni_stream_checker.sv
dv/tls_client_hello_sni_extractor_tb.sv
